// ===== rtl/dhaq_pkg.sv =====
// Shared types and constants for the delayed hysteresis alarm qualifier.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package dhaq_pkg;

	// Field and counter widths
	localparam int TEMP_W   = 12;
	localparam int DELAY_W  = 15;
	localparam int OFFSET_W = 8;
	localparam int MIN_W    = 8;
	localparam int CNT_W    = 16;
	localparam int DATA_W   = 32;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W   = REG_IDX_W + 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Register reset values
	localparam logic signed [TEMP_W-1:0]   CAB_HIGH_LIMIT_RST = 12'sd0;
	localparam logic signed [TEMP_W-1:0]   CAB_LOW_LIMIT_RST  = -12'sd800;
	localparam logic [DELAY_W-1:0]         CAB_HIGH_DELAY_RST = 15'd600;
	localparam logic [DELAY_W-1:0]         CAB_LOW_DELAY_RST  = 15'd600;
	localparam logic signed [TEMP_W-1:0]   AMB_LIMIT_RST      = 12'sd35;
	localparam logic signed [OFFSET_W-1:0] AMB_OFFSET_RST     = -8'sd1;
	localparam logic [DELAY_W-1:0]         AMB_DELAY_RST      = 15'd30;
	localparam logic [MIN_W-1:0]           DOOR_MIN_RST       = 8'd5;

	// Register map, one register per 32-bit word
	typedef enum logic [REG_IDX_W-1:0] {
		REG_CAB_HIGH_LIMIT   = 3'd0,
		REG_CAB_LOW_LIMIT    = 3'd1,
		REG_CAB_HIGH_DELAY   = 3'd2,
		REG_CAB_LOW_DELAY    = 3'd3,
		REG_AMB_LIMIT        = 3'd4,
		REG_AMB_CLEAR_OFFSET = 3'd5,
		REG_AMB_DELAY        = 3'd6,
		REG_DOOR_DELAY_MIN   = 3'd7
	} cfg_reg_t;

	// Outcome of one persistence step
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             flag;
	} qual_t;

endpackage

// ===== rtl/dhaq_stream_if.sv =====
// Valid/ready channels for sample words in and alarm words out.
// Depends on dhaq_pkg for field widths.
`timescale 1ns / 1ps

interface dhaq_sample_if import dhaq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] cabinet_temp;
	logic                     cabinet_sensor_fault;
	logic signed [TEMP_W-1:0] ambient_temp;
	logic                     door_open;

	modport source (output valid, cabinet_temp, cabinet_sensor_fault, ambient_temp,
		door_open, input ready);
	modport sink (input valid, cabinet_temp, cabinet_sensor_fault, ambient_temp,
		door_open, output ready);
endinterface

interface dhaq_alarm_if import dhaq_pkg::*; ();
	logic valid;
	logic ready;
	logic cabinet_high_alarm;
	logic cabinet_low_alarm;
	logic ambient_high_alarm;
	logic door_alarm;

	modport source (output valid, cabinet_high_alarm, cabinet_low_alarm,
		ambient_high_alarm, door_alarm, input ready);
	modport sink (input valid, cabinet_high_alarm, cabinet_low_alarm,
		ambient_high_alarm, door_alarm, output ready);
endinterface

// ===== rtl/delayed_hysteresis_alarm_qualifier.sv =====
// Top level of the persistence-qualified alarm block: input register, step logic,
// alarm state and result register, plus the APB register file.
// Depends on dhaq_pkg and the channel interfaces in dhaq_stream_if.sv.
`timescale 1ns / 1ps

// One sample word per one-second tick goes in and one alarm word comes out. The
// block takes a word in every clock cycle while the result side does not stall.
// A word waits in the input register until the result register is free; its
// alarm word is then written into the result register, alongside the alarm
// counters, and leaves from there. The cabinet high and low alarms, and the
// ambient alarm, set and clear only after their condition has persisted for the
// configured number of ticks; a cabinet sensor fault freezes the cabinet alarms
// and clears their counters. The door alarm sets after the door has been open
// for door_delay_minutes * TICKS_PER_MINUTE ticks and clears as soon as it
// closes. Registers sit at byte offsets 0x00..0x1C in list order; write them
// only while no word is in flight. There is no start-up sweep after reset.
module delayed_hysteresis_alarm_qualifier import dhaq_pkg::*; #(
	parameter int TICKS_PER_MINUTE = 60
) (
	input  logic                clk,
	input  logic                arst_n,
	dhaq_sample_if.sink         samples,
	dhaq_alarm_if.source        alarms,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int TPM_W      = $clog2(TICKS_PER_MINUTE + 1);
	localparam int DOOR_LIM_W = MIN_W + TPM_W;

	// Configuration registers
	logic signed [TEMP_W-1:0]   cab_high_limit_q;
	logic signed [TEMP_W-1:0]   cab_low_limit_q;
	logic [DELAY_W-1:0]         cab_high_delay_q;
	logic [DELAY_W-1:0]         cab_low_delay_q;
	logic signed [TEMP_W-1:0]   amb_limit_q;
	logic signed [OFFSET_W-1:0] amb_offset_q;
	logic [DELAY_W-1:0]         amb_delay_q;
	logic [MIN_W-1:0]           door_min_q;
	logic [DOOR_LIM_W-1:0]      door_limit_q;

	logic     cfg_wr;
	cfg_reg_t cfg_idx;

	// Input register
	logic                     valid_s1;
	logic signed [TEMP_W-1:0] cab_temp_s1;
	logic                     fault_s1;
	logic signed [TEMP_W-1:0] amb_temp_s1;
	logic                     door_s1;

	// Alarm state; the flags double as the result payload
	logic [CNT_W-1:0] high_cnt_q, low_cnt_q, amb_cnt_q, door_cnt_q;
	logic             high_flag_q, low_flag_q, amb_flag_q, door_flag_q;
	logic             out_valid_q;

	logic  advance;
	logic  step;
	logic  high_cond, low_cond, amb_cond;
	logic signed [TEMP_W:0] amb_clear;
	qual_t high_nxt, low_nxt, amb_nxt;
	logic [CNT_W-1:0] door_inc;

	// One persistence step: count while cond holds, toggle on reaching the delay
	function automatic qual_t qualify(input logic cond, input logic [DELAY_W-1:0] delay,
		input logic [CNT_W-1:0] cnt, input logic flag);
		qual_t            r;
		logic [CNT_W-1:0] inc;
		inc = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
		if (!cond) begin
			r.cnt  = '0;
			r.flag = flag;
		end else if (inc >= CNT_W'(delay)) begin
			r.cnt  = '0;
			r.flag = !flag;
		end else begin
			r.cnt  = inc;
			r.flag = flag;
		end
		return r;
	endfunction

	// APB register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cab_high_limit_q <= CAB_HIGH_LIMIT_RST;
			cab_low_limit_q  <= CAB_LOW_LIMIT_RST;
			cab_high_delay_q <= CAB_HIGH_DELAY_RST;
			cab_low_delay_q  <= CAB_LOW_DELAY_RST;
			amb_limit_q      <= AMB_LIMIT_RST;
			amb_offset_q     <= AMB_OFFSET_RST;
			amb_delay_q      <= AMB_DELAY_RST;
			door_min_q       <= DOOR_MIN_RST;
			door_limit_q     <= DOOR_LIM_W'(int'(DOOR_MIN_RST) * TICKS_PER_MINUTE);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CAB_HIGH_LIMIT:   cab_high_limit_q <= pwdata[TEMP_W-1:0];
				REG_CAB_LOW_LIMIT:    cab_low_limit_q  <= pwdata[TEMP_W-1:0];
				REG_CAB_HIGH_DELAY:   cab_high_delay_q <= pwdata[DELAY_W-1:0];
				REG_CAB_LOW_DELAY:    cab_low_delay_q  <= pwdata[DELAY_W-1:0];
				REG_AMB_LIMIT:        amb_limit_q      <= pwdata[TEMP_W-1:0];
				REG_AMB_CLEAR_OFFSET: amb_offset_q     <= pwdata[OFFSET_W-1:0];
				REG_AMB_DELAY:        amb_delay_q      <= pwdata[DELAY_W-1:0];
				REG_DOOR_DELAY_MIN: begin
					door_min_q   <= pwdata[MIN_W-1:0];
					// precompute the door threshold in ticks
					door_limit_q <= {{TPM_W{1'b0}}, pwdata[MIN_W-1:0]}
						* DOOR_LIM_W'(TICKS_PER_MINUTE);
				end
			endcase
		end
	end

	// Read back, signed registers sign-extended
	always_comb begin
		unique case (cfg_idx)
			REG_CAB_HIGH_LIMIT:
				prdata = {{(DATA_W-TEMP_W){cab_high_limit_q[TEMP_W-1]}}, cab_high_limit_q};
			REG_CAB_LOW_LIMIT:
				prdata = {{(DATA_W-TEMP_W){cab_low_limit_q[TEMP_W-1]}}, cab_low_limit_q};
			REG_CAB_HIGH_DELAY:
				prdata = {{(DATA_W-DELAY_W){1'b0}}, cab_high_delay_q};
			REG_CAB_LOW_DELAY:
				prdata = {{(DATA_W-DELAY_W){1'b0}}, cab_low_delay_q};
			REG_AMB_LIMIT:
				prdata = {{(DATA_W-TEMP_W){amb_limit_q[TEMP_W-1]}}, amb_limit_q};
			REG_AMB_CLEAR_OFFSET:
				prdata = {{(DATA_W-OFFSET_W){amb_offset_q[OFFSET_W-1]}}, amb_offset_q};
			REG_AMB_DELAY:
				prdata = {{(DATA_W-DELAY_W){1'b0}}, amb_delay_q};
			REG_DOOR_DELAY_MIN:
				prdata = {{(DATA_W-MIN_W){1'b0}}, door_min_q};
		endcase
	end

	// Handshake: the input register moves on whenever the result register is free
	assign advance       = !out_valid_q || alarms.ready;
	assign samples.ready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	// Capture the sample word
	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			cab_temp_s1 <= samples.cabinet_temp;
			fault_s1    <= samples.cabinet_sensor_fault;
			amb_temp_s1 <= samples.ambient_temp;
			door_s1     <= samples.door_open;
		end
	end

	// Conditions that would flip each alarm
	assign high_cond = high_flag_q ? (cab_temp_s1 < cab_high_limit_q)
		: (cab_temp_s1 >= cab_high_limit_q);
	assign low_cond  = low_flag_q ? (cab_temp_s1 > cab_low_limit_q)
		: (cab_temp_s1 <= cab_low_limit_q);
	assign amb_clear = {amb_limit_q[TEMP_W-1], amb_limit_q}
		+ {{(TEMP_W+1-OFFSET_W){amb_offset_q[OFFSET_W-1]}}, amb_offset_q};
	assign amb_cond  = amb_flag_q
		? ($signed({amb_temp_s1[TEMP_W-1], amb_temp_s1}) <= amb_clear)
		: (amb_temp_s1 > amb_limit_q);

	assign high_nxt = qualify(high_cond, cab_high_delay_q, high_cnt_q, high_flag_q);
	assign low_nxt  = qualify(low_cond, cab_low_delay_q, low_cnt_q, low_flag_q);
	assign amb_nxt  = qualify(amb_cond, amb_delay_q, amb_cnt_q, amb_flag_q);
	assign door_inc = (door_cnt_q == CNT_MAX) ? door_cnt_q : door_cnt_q + 1'b1;

	// Advance alarm state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_cnt_q  <= '0;
			low_cnt_q   <= '0;
			amb_cnt_q   <= '0;
			door_cnt_q  <= '0;
			high_flag_q <= 1'b0;
			low_flag_q  <= 1'b0;
			amb_flag_q  <= 1'b0;
			door_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (step) begin
				// hold the cabinet alarms while the sensor is faulty
				if (fault_s1) begin
					high_cnt_q <= '0;
					low_cnt_q  <= '0;
				end else begin
					high_cnt_q  <= high_nxt.cnt;
					high_flag_q <= high_nxt.flag;
					low_cnt_q   <= low_nxt.cnt;
					low_flag_q  <= low_nxt.flag;
				end
				amb_cnt_q  <= amb_nxt.cnt;
				amb_flag_q <= amb_nxt.flag;
				// door: count while open and not yet alarmed, drop on close
				if (!door_s1) begin
					door_cnt_q  <= '0;
					door_flag_q <= 1'b0;
				end else if (!door_flag_q) begin
					if (door_inc >= CNT_W'(door_limit_q)) begin
						door_cnt_q  <= '0;
						door_flag_q <= 1'b1;
					end else begin
						door_cnt_q <= door_inc;
					end
				end
			end
		end
	end

	assign alarms.valid              = out_valid_q;
	assign alarms.cabinet_high_alarm = high_flag_q;
	assign alarms.cabinet_low_alarm  = low_flag_q;
	assign alarms.ambient_high_alarm = amb_flag_q;
	assign alarms.door_alarm         = door_flag_q;

`ifndef SYNTH
	// A set door alarm always has a cleared counter
	a_door_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		door_flag_q |-> (door_cnt_q == '0))
		else $error("door counter running while door alarm set");

	// A faulty-sensor tick clears the cabinet counters and keeps the cabinet alarms
	a_fault_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(step && fault_s1) |=> (high_cnt_q == '0) && (low_cnt_q == '0)
			&& (high_flag_q == $past(high_flag_q)) && (low_flag_q == $past(low_flag_q)))
		else $error("cabinet alarms not frozen on sensor fault");

	// Alarm state moves only when a word is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable({high_flag_q, low_flag_q, amb_flag_q, door_flag_q,
			high_cnt_q, low_cnt_q, amb_cnt_q, door_cnt_q}))
		else $error("alarm state changed without a word");

	// A processed word always lands in the result register
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("processed word produced no result");

	// A closed door leaves no door alarm behind
	a_door_close: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !door_s1) |=> !door_flag_q && (door_cnt_q == '0))
		else $error("door alarm survived a closed door");
`endif

endmodule

// ===== tb/alarm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the alarm qualifier: watches the sample, alarm and register ports,
// predicts each alarm word and compares it. Depends on dhaq_pkg and dhaq_stream_if.sv.

module alarm_checker import dhaq_pkg::*; #(
	parameter int TICKS_PER_MINUTE = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	dhaq_sample_if            samples,
	dhaq_alarm_if             alarms,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic high;
		logic low;
		logic ambient;
		logic door;
	} alarm_word_t;

	// Shadow copy of the register file
	logic signed [TEMP_W-1:0]   high_limit, low_limit, amb_limit;
	logic signed [OFFSET_W-1:0] amb_offset;
	logic [DELAY_W-1:0]         high_delay, low_delay, amb_delay;
	logic [MIN_W-1:0]           door_minutes;

	// Predicted alarm state: persistence counter and flag per alarm
	qual_t high_q, low_q, amb_q, door_q;

	alarm_word_t expected_alarms[$];
	int          errors;

	// Advance one persistence counter; toggle the flag once it reaches the delay
	function automatic qual_t persist(input logic cond, input logic [DELAY_W-1:0] delay,
		input qual_t cur);
		qual_t nxt;
		nxt = cur;
		if (cond) begin
			if (nxt.cnt != CNT_MAX)
				nxt.cnt = nxt.cnt + 1'b1;
			if (nxt.cnt >= {1'b0, delay}) begin
				nxt.cnt  = '0;
				nxt.flag = ~nxt.flag;
			end
		end else begin
			nxt.cnt = '0;
		end
		return nxt;
	endfunction

	// Apply one tick to the shadow state and return the alarm word it yields
	function automatic alarm_word_t step_alarms(input logic signed [TEMP_W-1:0] cab,
		input logic fault, input logic signed [TEMP_W-1:0] amb, input logic door);
		alarm_word_t w;
		int          amb_clear;
		int          door_ticks;
		amb_clear  = int'(amb_limit) + int'(amb_offset);
		door_ticks = int'(door_minutes) * TICKS_PER_MINUTE;

		// Freeze the cabinet alarms while the sensor is faulty
		if (fault) begin
			high_q.cnt = '0;
			low_q.cnt  = '0;
		end else begin
			high_q = persist(high_q.flag ? (cab < high_limit) : (cab >= high_limit),
				high_delay, high_q);
			low_q = persist(low_q.flag ? (cab > low_limit) : (cab <= low_limit),
				low_delay, low_q);
		end

		// Clear the ambient alarm at the limit shifted by the signed offset
		amb_q = persist(amb_q.flag ? (int'(amb) <= amb_clear) : (amb > amb_limit),
			amb_delay, amb_q);

		// Hold the door counter once the alarm is up; drop both when the door shuts
		if (door) begin
			if (!door_q.flag) begin
				if (door_q.cnt != CNT_MAX)
					door_q.cnt = door_q.cnt + 1'b1;
				if (int'(door_q.cnt) >= door_ticks) begin
					door_q.cnt  = '0;
					door_q.flag = 1'b1;
				end
			end
		end else begin
			door_q = '0;
		end

		w.high    = high_q.flag;
		w.low     = low_q.flag;
		w.ambient = amb_q.flag;
		w.door    = door_q.flag;
		return w;
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0b actual %0b", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alarm_word_t want;
		if (!arst_n) begin
			high_limit   = CAB_HIGH_LIMIT_RST;
			low_limit    = CAB_LOW_LIMIT_RST;
			high_delay   = CAB_HIGH_DELAY_RST;
			low_delay    = CAB_LOW_DELAY_RST;
			amb_limit    = AMB_LIMIT_RST;
			amb_offset   = AMB_OFFSET_RST;
			amb_delay    = AMB_DELAY_RST;
			door_minutes = DOOR_MIN_RST;
			high_q       = '0;
			low_q        = '0;
			amb_q        = '0;
			door_q       = '0;
			errors       = 0;
			expected_alarms.delete();
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (cfg_reg_t'(paddr[ADDR_W-1:2]))
					REG_CAB_HIGH_LIMIT:   high_limit   = pwdata[TEMP_W-1:0];
					REG_CAB_LOW_LIMIT:    low_limit    = pwdata[TEMP_W-1:0];
					REG_CAB_HIGH_DELAY:   high_delay   = pwdata[DELAY_W-1:0];
					REG_CAB_LOW_DELAY:    low_delay    = pwdata[DELAY_W-1:0];
					REG_AMB_LIMIT:        amb_limit    = pwdata[TEMP_W-1:0];
					REG_AMB_CLEAR_OFFSET: amb_offset   = pwdata[OFFSET_W-1:0];
					REG_AMB_DELAY:        amb_delay    = pwdata[DELAY_W-1:0];
					REG_DOOR_DELAY_MIN:   door_minutes = pwdata[MIN_W-1:0];
					default: ;
				endcase
			end

			// Compare each accepted alarm word with the oldest prediction
			if (alarms.valid && alarms.ready) begin
				if (expected_alarms.size() == 0) begin
					errors++;
					$display("%0t: alarm word with none expected, actual %b%b%b%b", $time,
						alarms.cabinet_high_alarm, alarms.cabinet_low_alarm,
						alarms.ambient_high_alarm, alarms.door_alarm);
				end else begin
					want = expected_alarms.pop_front();
					check_field("cabinet_high_alarm", want.high, alarms.cabinet_high_alarm);
					check_field("cabinet_low_alarm", want.low, alarms.cabinet_low_alarm);
					check_field("ambient_high_alarm", want.ambient, alarms.ambient_high_alarm);
					check_field("door_alarm", want.door, alarms.door_alarm);
				end
			end

			// Predict the word for each accepted sample
			if (samples.valid && samples.ready)
				expected_alarms.push_back(step_alarms(samples.cabinet_temp,
					samples.cabinet_sensor_fault, samples.ambient_temp, samples.door_open));
		end
		fail_count <= errors;
		pending    <= expected_alarms.size();
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the alarm qualifier testbench: clock, reset, register writes, sample stimulus
// and the verdict. Depends on dhaq_pkg, dhaq_stream_if.sv, the RTL top and alarm_checker.

module testbench import dhaq_pkg::*;;

	localparam int TICKS = 60;
	localparam int STALL_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;

	bit idling_on = 1'b1;
	int cfg_val [8];
	int cab_mode, amb_mode;
	bit fault_state, door_state;
	int stall_cycles;

	dhaq_sample_if samples ();
	dhaq_alarm_if  alarms ();

	delayed_hysteresis_alarm_qualifier #(.TICKS_PER_MINUTE(TICKS)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.alarms  (alarms),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	alarm_checker #(.TICKS_PER_MINUTE(TICKS)) i_alarm_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.alarms     (alarms),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// Stall the alarm side at random
	always @(negedge clk) begin
		alarms.ready = !(idling_on && $urandom_range(99) < 23);
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples.valid && samples.ready) || (alarms.valid && alarms.ready)
				|| (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	// Two-phase register write
	task automatic set_reg(input cfg_reg_t r, input int value);
		cfg_val[r] = value;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {r, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Offer one sample word, with random gaps ahead of it, and wait for acceptance
	task automatic send_tick(input int cab, input int fault, input int amb, input int door);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < 23) begin
			samples.valid = 1'b0;
			@(negedge clk);
		end
		samples.valid                = 1'b1;
		samples.cabinet_temp         = cab[TEMP_W-1:0];
		samples.cabinet_sensor_fault = fault[0];
		samples.ambient_temp         = amb[TEMP_W-1:0];
		samples.door_open            = door[0];
		do @(posedge clk); while (!samples.ready);
	endtask

	// Hold the sender until every predicted alarm word has come back
	task automatic wait_drained();
		@(negedge clk);
		samples.valid = 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Pick a temperature in a window around base, clamped to the sensor range
	function automatic int near(input int base, input int lo_off, input int hi_off);
		int v;
		v = base + lo_off + int'($urandom_range(hi_off - lo_off));
		if (v > 2047)
			v = 2047;
		if (v < -2048)
			v = -2048;
		return v;
	endfunction

	// Random ticks that dwell near the thresholds long enough to qualify
	task automatic run_random(input int n_items, input bit pause_midway);
		int cab, amb, fault_in, door_in;
		for (int i = 0; i < n_items; i++) begin
			if (pause_midway && i == n_items / 2)
				wait_drained();
			if ($urandom_range(99) < 8)
				cab_mode = $urandom_range(3);
			if ($urandom_range(99) < 8)
				amb_mode = $urandom_range(3);
			if (fault_state ? ($urandom_range(99) < 20) : ($urandom_range(99) < 2))
				fault_state = ~fault_state;
			if ($urandom_range(999) < 15)
				door_state = ~door_state;

			case (cab_mode)
				0: cab = near(cfg_val[REG_CAB_HIGH_LIMIT], 0, 40);
				1: cab = near(cfg_val[REG_CAB_LOW_LIMIT], -40, 0);
				2: cab = near((cfg_val[REG_CAB_HIGH_LIMIT] + cfg_val[REG_CAB_LOW_LIMIT]) / 2,
					-20, 20);
				default: cab = int'($urandom_range(4095)) - 2048;
			endcase
			case (amb_mode)
				0: amb = near(cfg_val[REG_AMB_LIMIT], 1, 40);
				1: amb = near(cfg_val[REG_AMB_LIMIT] + cfg_val[REG_AMB_CLEAR_OFFSET], -40, 0);
				2: amb = near(cfg_val[REG_AMB_LIMIT], -5, 5);
				default: amb = int'($urandom_range(4095)) - 2048;
			endcase
			// Add the odd glitch on the fault and door lines
			fault_in = ($urandom_range(99) < 3) ? !fault_state : fault_state;
			door_in  = ($urandom_range(99) < 2) ? !door_state : door_state;
			send_tick(cab, fault_in, amb, door_in);
		end
	endtask

	task automatic load_config(input int hi, input int lo, input int hd, input int ld,
		input int al, input int off, input int ad, input int dm);
		wait_drained();
		set_reg(REG_CAB_HIGH_LIMIT, hi);
		set_reg(REG_CAB_LOW_LIMIT, lo);
		set_reg(REG_CAB_HIGH_DELAY, hd);
		set_reg(REG_CAB_LOW_DELAY, ld);
		set_reg(REG_AMB_LIMIT, al);
		set_reg(REG_AMB_CLEAR_OFFSET, off);
		set_reg(REG_AMB_DELAY, ad);
		set_reg(REG_DOOR_DELAY_MIN, dm);
	endtask

	initial begin
		arst_n                       = 1'b0;
		psel                         = 1'b0;
		penable                      = 1'b0;
		pwrite                       = 1'b0;
		paddr                        = '0;
		pwdata                       = '0;
		samples.valid                = 1'b0;
		samples.cabinet_temp         = '0;
		samples.cabinet_sensor_fault = 1'b0;
		samples.ambient_temp         = '0;
		samples.door_open            = 1'b0;
		alarms.ready                 = 1'b0;
		stall_cycles                 = 0;
		cab_mode                     = 3;
		amb_mode                     = 3;
		fault_state                  = 1'b0;
		door_state                   = 1'b0;
		cfg_val = '{int'(CAB_HIGH_LIMIT_RST), int'(CAB_LOW_LIMIT_RST),
			int'(CAB_HIGH_DELAY_RST), int'(CAB_LOW_DELAY_RST), int'(AMB_LIMIT_RST),
			int'(AMB_OFFSET_RST), int'(AMB_DELAY_RST), int'(DOOR_MIN_RST)};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Two words under the reset settings
		send_tick(0, 0, 36, 1);
		send_tick(-800, 0, 36, 1);

		// Directed: zero cabinet high delay, immediate door alarm, fault freeze, field extremes
		load_config(100, -100, 0, 1, 50, -10, 2, 0);
		send_tick(2047, 0, -2048, 1);
		send_tick(-2048, 0, 2047, 1);
		send_tick(-2048, 0, 2047, 1);
		send_tick(-2048, 1, 2047, 0);
		send_tick(2047, 1, -2048, 0);
		send_tick(2047, 0, -2048, 0);
		send_tick(100, 0, 40, 1);
		send_tick(99, 0, 41, 1);
		send_tick(-100, 0, 50, 0);
		send_tick(-99, 0, 51, 0);
		send_tick(-101, 0, 51, 1);
		send_tick(0, 0, 0, 0);
		send_tick(2047, 0, 2047, 1);
		send_tick(-2048, 0, -2048, 0);
		send_tick(100, 1, 40, 1);
		send_tick(-100, 0, 39, 0);

		// Short delays, widest negative clearing offset, one-minute door
		load_config(200, -200, 3, 5, 40, -128, 4, 1);
		run_random(250, 1'b1);

		// Limits at the range ends, longest delays, immediate ambient
		load_config(2047, -2048, 32767, 32767, -2048, 127, 0, 255);
		run_random(150, 1'b0);

		// Inverted cabinet limits, zero offset, two-minute door
		load_config(-2048, 2047, 1, 0, 2047, 0, 1, 2);
		run_random(220, 1'b0);

		// Near-reset limits; first 120 words with no idling on either side
		load_config(0, -800, 10, 10, 35, -1, 6, 1);
		idling_on = 1'b0;
		run_random(120, 1'b0);
		idling_on = 1'b1;
		run_random(180, 1'b1);

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dhaq_pkg.sv
rtl/dhaq_stream_if.sv
rtl/delayed_hysteresis_alarm_qualifier.sv
tb/alarm_checker.sv
tb/testbench.sv
